// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ile assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ILE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ile assertion failed");

`endif

// ===== design/ile_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Sizes, request and status codes, and the command broadcast to the cells.
// ----------------------------------------------------------------------------
package ile_pkg;

  // List capacity and entry width
  localparam int DEPTH  = 64;
  localparam int ITEM_W = 32;

  // Port field widths (fixed by the interface)
  localparam int REQ_W  = 3;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int NLEN_W = 7;

  // Length counter holds 0..DEPTH
  localparam int CNT_W = $clog2(DEPTH + 1);
  // Common width for comparing a position against the length
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef logic [ITEM_W-1:0] item_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CMP_W-1:0]  cmp_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [NLEN_W-1:0] nlen_t;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_INSERT = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_SET    = 3'd4,
    REQ_REMALL = 3'd5
  } req_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BOUNDS = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Per-cycle action of the cell row
  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_PUSH   = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SET    = 3'd4,
    OP_ROTATE = 3'd5
  } cell_op_e;

  // Command broadcast to every cell
  typedef struct packed {
    cell_op_e op;    // action this cycle
    cnt_t     pos;   // target index (write slot, gap, or rotate tail)
    logic     keep;  // rotate: head entry re-enters at the tail
    cnt_t     take;  // index whose entry is read out
  } cell_ctrl_t;

endpackage

// ===== design/ile_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_cell: one list slot
// Holds one entry and loads it from the request value, a neighbor, or the
// head of the row, as the broadcast command and its own index decide.
// ----------------------------------------------------------------------------
module ile_cell (
  input  logic                clk_i,
  input  ile_pkg::cell_ctrl_t ctrl_i,
  input  ile_pkg::cnt_t       idx_i,   // fixed slot index
  input  ile_pkg::item_t      val_i,   // request value
  input  ile_pkg::item_t      head_i,  // entry of slot 0
  input  ile_pkg::item_t      up_i,    // entry of slot idx+1
  input  ile_pkg::item_t      dn_i,    // entry of slot idx-1
  output ile_pkg::item_t      data_o,
  output ile_pkg::item_t      take_o
);

  ile_pkg::item_t entry_q, entry_d;

  // Next entry value
  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      ile_pkg::OP_PUSH, ile_pkg::OP_SET: begin
        if (idx_i == ctrl_i.pos) entry_d = val_i;
      end
      ile_pkg::OP_INSERT: begin
        if (idx_i == ctrl_i.pos)     entry_d = val_i;
        else if (idx_i > ctrl_i.pos) entry_d = dn_i;
      end
      ile_pkg::OP_REMOVE: begin
        if (idx_i >= ctrl_i.pos) entry_d = up_i;
      end
      ile_pkg::OP_ROTATE: begin
        // whole row moves down; the head re-enters at the tail if kept
        if (ctrl_i.keep && (idx_i == ctrl_i.pos)) entry_d = head_i;
        else                                      entry_d = up_i;
      end
      default: entry_d = entry_q;
    endcase
  end

  // Entry storage (payload, no reset)
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;
  assign take_o = (idx_i == ctrl_i.take) ? entry_q : '0;

endmodule

// ===== design/ile_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_chain: row of list cells
// Wires each cell to its neighbors and the head slot, and merges the
// one-hot read-out of the selected entry.
// ----------------------------------------------------------------------------
module ile_chain (
  input  logic                clk_i,
  input  ile_pkg::cell_ctrl_t ctrl_i,
  input  ile_pkg::item_t      val_i,
  output ile_pkg::item_t      head_o,
  output ile_pkg::item_t      take_o
);

  ile_pkg::item_t data_w [ile_pkg::DEPTH];
  ile_pkg::item_t take_w [ile_pkg::DEPTH];

  // Cell row
  for (genvar k = 0; k < ile_pkg::DEPTH; k++) begin : g_cell
    ile_pkg::item_t up_w, dn_w;

    if (k == ile_pkg::DEPTH - 1) begin : g_top
      assign up_w = '0;
    end else begin : g_mid_up
      assign up_w = data_w[k+1];
    end

    if (k == 0) begin : g_bot
      assign dn_w = '0;
    end else begin : g_mid_dn
      assign dn_w = data_w[k-1];
    end

    ile_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .idx_i  (ile_pkg::cnt_t'(k)),
      .val_i  (val_i),
      .head_i (data_w[0]),
      .up_i   (up_w),
      .dn_i   (dn_w),
      .data_o (data_w[k]),
      .take_o (take_w[k])
    );
  end

  // Merge of the read-out; at most one cell is selected
  always_comb begin
    take_o = '0;
    for (int k = 0; k < ile_pkg::DEPTH; k++) begin
      take_o = take_o | take_w[k];
    end
  end

  assign head_o = data_w[0];

endmodule

// ===== design/indexed_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_engine: ordered list with indexed insert and delete
// Push, pop, insert, remove, set and remove-all-equal on a row of cells.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+--------------------------------------
//  request  | start_i / busy_o       | req_type_i, position_i, item_value_i
//  result   | done_o (one-cycle)     | status_o, taken_value_o, new_length_o
//
// A request transfers on the edge with start_i high and busy_o low. The next
// cycle updates every cell at once; done_o follows in the cycle after, and a
// new request is taken in that same cycle.
// Remove-all-equal rotates the list once through the head cell, one entry per
// cycle; on an empty list it finishes like any other request.
// Reset clears the length and the control state; entries need no clearing.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
module indexed_list_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [ile_pkg::REQ_W-1:0]      req_type_i,
  input  logic [ile_pkg::POS_W-1:0]      position_i,
  input  logic [ile_pkg::VAL_W-1:0]      item_value_i,
  output logic                           done_o,
  output logic [ile_pkg::STAT_W-1:0]     status_o,
  output logic [ile_pkg::VAL_W-1:0]      taken_value_o,
  output logic [ile_pkg::NLEN_W-1:0]     new_length_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_PACK = 3'b100
  } state_e;

  state_e              state_q, state_d;
  ile_pkg::cnt_t       len_q, len_d;
  ile_pkg::cnt_t       steps_q, steps_d;
  logic                done_q, done_d;
  ile_pkg::status_e    status_q, status_d;
  ile_pkg::item_t      taken_q, taken_d;
  ile_pkg::cnt_t       nlen_q, nlen_d;

  logic [ile_pkg::REQ_W-1:0] req_q;
  ile_pkg::pos_t       pos_q;
  ile_pkg::item_t      val_q;

  ile_pkg::cell_ctrl_t ctrl;
  ile_pkg::item_t      head_w;
  ile_pkg::item_t      take_w;

  logic                accept;
  logic                full;
  logic                pos_gt_len;
  logic                pos_ge_len;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      pos_q <= position_i;
      val_q <= ile_pkg::item_t'(item_value_i);
    end
  end

  // Bounds and capacity tests
  assign full       = (len_q == ile_pkg::cnt_t'(ile_pkg::DEPTH));
  assign pos_gt_len = (ile_pkg::cmp_t'(pos_q) >  ile_pkg::cmp_t'(len_q));
  assign pos_ge_len = (ile_pkg::cmp_t'(pos_q) >= ile_pkg::cmp_t'(len_q));

  // Sequencer and cell command
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    steps_d  = steps_q;
    done_d   = 1'b0;
    status_d = status_q;
    taken_d  = taken_q;
    nlen_d   = nlen_q;
    ctrl     = '{op: ile_pkg::OP_HOLD, pos: '0, keep: 1'b0, take: '0};

    case (state_q)
      S_IDLE: begin
        if (start_i) state_d = S_EXEC;
      end

      S_EXEC: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = ile_pkg::ST_OK;
        taken_d  = '0;
        case (req_q)
          ile_pkg::REQ_PUSH: begin
            if (full) begin
              status_d = ile_pkg::ST_FULL;
            end else begin
              ctrl.op  = ile_pkg::OP_PUSH;
              ctrl.pos = len_q;
              len_d    = len_q + 1'b1;
            end
          end
          ile_pkg::REQ_POP: begin
            if (len_q == '0) begin
              status_d = ile_pkg::ST_EMPTY;
            end else begin
              ctrl.take = len_q - 1'b1;
              taken_d   = take_w;
              len_d     = len_q - 1'b1;
            end
          end
          ile_pkg::REQ_INSERT: begin
            if (pos_gt_len) begin
              status_d = ile_pkg::ST_BOUNDS;
            end else if (full) begin
              status_d = ile_pkg::ST_FULL;
            end else begin
              ctrl.op  = ile_pkg::OP_INSERT;
              ctrl.pos = ile_pkg::cnt_t'(pos_q);
              len_d    = len_q + 1'b1;
            end
          end
          ile_pkg::REQ_REMOVE: begin
            if (pos_ge_len) begin
              status_d = ile_pkg::ST_BOUNDS;
            end else begin
              ctrl.op   = ile_pkg::OP_REMOVE;
              ctrl.pos  = ile_pkg::cnt_t'(pos_q);
              ctrl.take = ile_pkg::cnt_t'(pos_q);
              taken_d   = take_w;
              len_d     = len_q - 1'b1;
            end
          end
          ile_pkg::REQ_SET: begin
            if (pos_ge_len) begin
              status_d = ile_pkg::ST_BOUNDS;
            end else begin
              ctrl.op  = ile_pkg::OP_SET;
              ctrl.pos = ile_pkg::cnt_t'(pos_q);
            end
          end
          ile_pkg::REQ_REMALL: begin
            // rotate every entry once through the head cell
            if (len_q != '0) begin
              state_d = S_PACK;
              done_d  = 1'b0;
              steps_d = len_q;
            end
          end
          default: ;
        endcase
        nlen_d = len_d;
      end

      S_PACK: begin
        // head leaves; it re-enters at the tail unless it matches
        ctrl.op   = ile_pkg::OP_ROTATE;
        ctrl.pos  = len_q - 1'b1;
        ctrl.keep = (head_w != val_q);
        if (!ctrl.keep) len_d = len_q - 1'b1;
        steps_d = steps_q - 1'b1;
        if (steps_q == ile_pkg::cnt_t'(1)) begin
          state_d  = S_IDLE;
          done_d   = 1'b1;
          status_d = ile_pkg::ST_OK;
          taken_d  = '0;
          nlen_d   = len_d;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      steps_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      steps_q <= steps_d;
      done_q  <= done_d;
    end
  end

  // Result registers (payload)
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    taken_q  <= taken_d;
    nlen_q   <= nlen_d;
  end

  // Cell row
  ile_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .val_i  (val_q),
    .head_o (head_w),
    .take_o (take_w)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign taken_value_o = ile_pkg::val_t'(taken_q);
  assign new_length_o  = ile_pkg::nlen_t'(nlen_q);

endmodule

// ===== design/ile_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ile_checker: port-level checks of the indexed list engine
// Watches the request handshake, the result strobe and the result fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ile_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic                           done_o,
  input logic [ile_pkg::STAT_W-1:0]     status_o,
  input logic [ile_pkg::VAL_W-1:0]      taken_value_o,
  input logic [ile_pkg::NLEN_W-1:0]     new_length_o
);

  // A transfer in always makes the engine busy next cycle
  `ILE_ASSERT_NXT(a_start_busy, start_i && !busy_o, busy_o)

  // Results never come back to back
  `ILE_ASSERT_NXT(a_done_pulse, done_o, !done_o)

  // Pop on an empty list leaves it empty
  `ILE_ASSERT_IMP(a_empty_len, done_o && (status_o == ile_pkg::ST_EMPTY), new_length_o == '0)

  // A failed request takes nothing out
  `ILE_ASSERT_IMP(a_fail_zero, done_o && (status_o != ile_pkg::ST_OK), taken_value_o == '0)

  // A full status only happens at capacity
  `ILE_ASSERT_IMP(a_full_len, done_o && (status_o == ile_pkg::ST_FULL),
                  new_length_o == ile_pkg::nlen_t'(ile_pkg::DEPTH))

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .done_o        (done_o),
  .status_o      (status_o),
  .taken_value_o (taken_value_o),
  .new_length_o  (new_length_o)
);
